// ----- sv/char_lcd_write_sequencer_assert.svh -----
// Assertion macros for the character LCD write sequencer.
// Included by files that carry concurrent checks; expects clk and arst_n in scope.
`ifndef CHAR_LCD_WRITE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_WRITE_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define CLWS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CLWS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/clws_pkg.sv -----
// Shared types, codes and LCD constants for the character LCD write sequencer.
// No dependencies.
`timescale 1ns / 1ps

package clws_pkg;

	localparam int COL_W  = 6;
	localparam int PAD_W  = 5;
	localparam int STEP_W = 3;

	localparam logic [COL_W-1:0]  COL_MAX   = 6'd63;
	localparam logic [PAD_W-1:0]  PAD_MAX   = 5'd16;
	localparam logic [STEP_W-1:0] INIT_LAST = 3'd5;

	// HD44780 command and data bytes
	localparam logic [7:0] CMD_WAKE     = 8'h33;
	localparam logic [7:0] CMD_FUNC_SET = 8'h38;
	localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
	localparam logic [7:0] CMD_CLEAR    = 8'h01;
	localparam logic [7:0] ADDR_LINE1   = 8'h80;
	localparam logic [7:0] ADDR_LINE2   = 8'hC0;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;

	// waits in ms
	localparam logic [4:0] WAIT_NONE     = 5'd0;
	localparam logic [4:0] WAIT_POWER_UP = 5'd20;
	localparam logic [4:0] WAIT_CLEAR    = 5'd25;
	localparam logic [4:0] WAIT_CMD      = 5'd5;
	localparam logic [4:0] WAIT_ADDR     = 5'd10;
	localparam logic [4:0] WAIT_DATA     = 5'd2;

	localparam logic RS_CMD  = 1'b0;
	localparam logic RS_DATA = 1'b1;

	typedef enum logic [1:0] {
		REQ_INIT = 2'd0,
		REQ_LINE = 2'd1,
		REQ_CHAR = 2'd2,
		REQ_END  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		WK_INIT  = 2'd0,
		WK_LINE  = 2'd1,
		WK_CHAR  = 2'd2,
		WK_SPACE = 2'd3
	} wr_kind_t;

	// controller -> datapath
	typedef struct packed {
		logic              load;
		logic              emit;
		wr_kind_t          kind;
		logic [STEP_W-1:0] step;
		logic              last;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic             out_free;
		logic [PAD_W-1:0] pad_cnt;
	} dp_status_t;

	function automatic logic [7:0] init_byte(input logic [STEP_W-1:0] step);
		logic [7:0] b;
		case (step)
			3'd0, 3'd1, 3'd2: b = CMD_WAKE;
			3'd3:             b = CMD_FUNC_SET;
			3'd4:             b = CMD_DISP_ON;
			default:          b = CMD_CLEAR;
		endcase
		return b;
	endfunction

endpackage

// ----- sv/clws_req_if.sv -----
// Request channel interface: valid/ready plus the request fields.
// No dependencies.
`timescale 1ns / 1ps

interface clws_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] char_code;
	logic       line_sel;
	logic       pad_rest;

	modport source (output valid, req_type, char_code, line_sel, pad_rest, input ready);
	modport sink   (input valid, req_type, char_code, line_sel, pad_rest, output ready);
endinterface

// ----- sv/clws_wr_if.sv -----
// Bus write channel interface: valid/ready plus one LCD write with its waits.
// No dependencies.
`timescale 1ns / 1ps

interface clws_wr_if;
	logic       valid;
	logic       ready;
	logic       reg_select;
	logic [7:0] bus_byte;
	logic [4:0] wait_before_ms;
	logic [4:0] wait_after_ms;
	logic       last_write;

	modport source (output valid, reg_select, bus_byte, wait_before_ms, wait_after_ms,
		last_write, input ready);
	modport sink   (input valid, reg_select, bus_byte, wait_before_ms, wait_after_ms,
		last_write, output ready);
endinterface

// ----- sv/clws_ctrl.sv -----
// Sequencing controller: accepts requests and steps through their writes.
// Depends on clws_pkg.
`timescale 1ns / 1ps

module clws_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	input  logic [1:0]             req_type,
	input  logic                   pad_rest,
	output logic                   req_ready,
	input  clws_pkg::dp_status_t   status,
	output clws_pkg::ctrl_cmd_t    cmd
);
	import clws_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_INIT = 4'b0010,
		ST_ONE  = 4'b0100,
		ST_PAD  = 4'b1000
	} state_t;

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic [PAD_W-1:0]  cnt_q, cnt_d;
	logic              is_line_q, is_line_d;
	logic              accept;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;

	always_comb begin
		state_d   = state_q;
		step_d    = step_q;
		cnt_d     = cnt_q;
		is_line_d = is_line_q;
		cmd       = '0;
		cmd.kind  = WK_INIT;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					case (req_t'(req_type))
						REQ_INIT: begin
							state_d = ST_INIT;
							step_d  = '0;
						end
						REQ_LINE: begin
							state_d   = ST_ONE;
							is_line_d = 1'b1;
						end
						REQ_CHAR: begin
							state_d   = ST_ONE;
							is_line_d = 1'b0;
						end
						default: begin
							// end of string: pad only if there is room left
							if (pad_rest && (status.pad_cnt != '0)) begin
								state_d = ST_PAD;
								cnt_d   = status.pad_cnt;
							end
						end
					endcase
				end
			end
			ST_INIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = WK_INIT;
					cmd.step = step_q;
					cmd.last = (step_q == INIT_LAST);
					step_d   = step_q + 1'b1;
					if (step_q == INIT_LAST)
						state_d = ST_IDLE;
				end
			end
			ST_ONE: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = is_line_q ? WK_LINE : WK_CHAR;
					cmd.last = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_PAD: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = WK_SPACE;
					cmd.last = (cnt_q == PAD_W'(1));
					cnt_d    = cnt_q - 1'b1;
					if (cnt_q == PAD_W'(1))
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			cnt_q     <= '0;
			is_line_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			step_q    <= step_d;
			cnt_q     <= cnt_d;
			is_line_q <= is_line_d;
		end
	end

endmodule

// ----- sv/clws_dp.sv -----
// Datapath: request field capture, column counter, pad length and output register.
// Depends on clws_pkg.
`timescale 1ns / 1ps

module clws_dp #(
	parameter int LINE_CHARS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            char_code,
	input  logic                  line_sel,
	input  clws_pkg::ctrl_cmd_t   cmd,
	output clws_pkg::dp_status_t  status,
	output logic                  wr_valid,
	input  logic                  wr_ready,
	output logic                  reg_select,
	output logic [7:0]            bus_byte,
	output logic [4:0]            wait_before_ms,
	output logic [4:0]            wait_after_ms,
	output logic                  last_write
);
	import clws_pkg::*;

	localparam logic [COL_W-1:0] LINE_LIM = COL_W'(LINE_CHARS);

	logic [7:0]       char_q;
	logic             line_q;
	logic [COL_W-1:0] col_q;
	logic [COL_W-1:0] col_inc;
	logic [COL_W-1:0] room;
	logic             valid_q;
	logic             rs_q;
	logic [7:0]       byte_q;
	logic [4:0]       before_q;
	logic [4:0]       after_q;
	logic             last_q;

	// spaces still needed on this line, capped at one burst; output register free
	always_comb begin
		status.out_free = !valid_q || wr_ready;
		room = LINE_LIM - col_q;
		if (col_q >= LINE_LIM)
			status.pad_cnt = '0;
		else if (room > {1'b0, PAD_MAX})
			status.pad_cnt = PAD_MAX;
		else
			status.pad_cnt = room[PAD_W-1:0];
	end

	assign col_inc = (col_q == COL_MAX) ? COL_MAX : col_q + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			char_q <= char_code;
			line_q <= line_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (cmd.emit) begin
			case (cmd.kind)
				WK_LINE:            col_q <= '0;
				WK_CHAR, WK_SPACE:  col_q <= col_inc;
				default:            col_q <= col_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (wr_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			last_q <= cmd.last;
			case (cmd.kind)
				WK_INIT: begin
					rs_q     <= RS_CMD;
					byte_q   <= init_byte(cmd.step);
					before_q <= (cmd.step == '0) ? WAIT_POWER_UP : WAIT_NONE;
					after_q  <= (cmd.step == INIT_LAST) ? WAIT_CLEAR : WAIT_CMD;
				end
				WK_LINE: begin
					rs_q     <= RS_CMD;
					byte_q   <= line_q ? ADDR_LINE2 : ADDR_LINE1;
					before_q <= WAIT_NONE;
					after_q  <= WAIT_ADDR;
				end
				WK_CHAR: begin
					rs_q     <= RS_DATA;
					byte_q   <= char_q;
					before_q <= WAIT_NONE;
					after_q  <= WAIT_DATA;
				end
				default: begin
					rs_q     <= RS_DATA;
					byte_q   <= CHAR_SPACE;
					before_q <= WAIT_NONE;
					after_q  <= WAIT_DATA;
				end
			endcase
		end
	end

	assign wr_valid       = valid_q;
	assign reg_select     = rs_q;
	assign bus_byte       = byte_q;
	assign wait_before_ms = before_q;
	assign wait_after_ms  = after_q;
	assign last_write     = last_q;

endmodule

// ----- sv/char_lcd_write_sequencer.sv -----
// Top level of the character LCD write sequencer: controller plus datapath.
// Depends on clws_pkg, clws_req_if, clws_wr_if, clws_ctrl, clws_dp and the assert header.
//
//   channel | dir | carries
//   --------+-----+----------------------------------------------------
//   req     | in  | req_type, char_code, line_sel, pad_rest
//   wr      | out | reg_select, bus_byte, wait_before_ms, wait_after_ms, last_write
//
// One write leaves per cycle while wr is ready; req is ready only while idle, and an
// accepted item then causes its writes (init 6, begin line 1, character 1, end 0..16),
// which the controller steps one at a time through the single output register.
// An end without padding causes no writes and leaves the block idle.
// Reset (arst_n low) clears the controller, the column counter and the output valid.
// A stall on wr holds the output register and the controller; req stays not ready while an item has writes left.
`timescale 1ns / 1ps
`include "char_lcd_write_sequencer_assert.svh"

module char_lcd_write_sequencer #(
	parameter int LINE_CHARS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	clws_req_if.sink         req,
	clws_wr_if.source        wr
);
	import clws_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// controller: request acceptance and write sequencing
	clws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.pad_rest  (req.pad_rest),
		.req_ready (req.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath: column counter, pad length, output register
	clws_dp #(
		.LINE_CHARS (LINE_CHARS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.char_code      (req.char_code),
		.line_sel       (req.line_sel),
		.cmd            (cmd),
		.status         (status),
		.wr_valid       (wr.valid),
		.wr_ready       (wr.ready),
		.reg_select     (wr.reg_select),
		.bus_byte       (wr.bus_byte),
		.wait_before_ms (wr.wait_before_ms),
		.wait_after_ms  (wr.wait_after_ms),
		.last_write     (wr.last_write)
	);

	// a new write never lands on a result that is still waiting
	`CLWS_ASSERT_NOW(a_no_overwrite, cmd.emit, status.out_free, "write issued over a pending result")

	// an init item keeps the block busy for its writes
	`CLWS_ASSERT_NEXT(a_init_busy, req.valid && req.ready && (req.req_type == REQ_INIT), !req.ready, "ready during init sequence")

	// after the final write of an item the block takes the next one
	`CLWS_ASSERT_NEXT(a_last_frees, cmd.emit && cmd.last, req.ready, "not ready after last write")

endmodule

// ----- verif/tb_char_lcd_write_sequencer.sv -----
// Self-checking testbench for char_lcd_write_sequencer: predicts the LCD bus writes of
// each request and checks them in order. Needs clws_pkg, clws_req_if, clws_wr_if and the RTL.
`timescale 1ns / 1ps

module tb_char_lcd_write_sequencer;
	import clws_pkg::*;

	localparam int          LINE_CHARS = 16;
	localparam int          MAX_SPACES = 16;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int          TAIL_CYCLES = 40;
	localparam int          RANDOM_REQS = 145;

	typedef struct {
		req_t       kind;
		logic [7:0] char_code;
		logic       line_sel;
		logic       pad_rest;
		bit         drain;     // hold this item back until no write is due
	} lcd_req_t;

	typedef struct {
		logic       reg_select;
		logic [7:0] bus_byte;
		logic [4:0] wait_before_ms;
		logic [4:0] wait_after_ms;
		logic       last_write;
	} lcd_write_t;

	logic clk = 1'b0;
	logic arst_n;

	clws_req_if req_ch();
	clws_wr_if  wr_ch();

	char_lcd_write_sequencer #(.LINE_CHARS(LINE_CHARS)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.wr     (wr_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	lcd_req_t    req_queue[$];
	lcd_write_t  lcd_writes_due[$];
	logic [5:0]  col_written = '0;   // characters on the current line, saturating
	int unsigned reqs_taken;
	int unsigned writes_outstanding;
	int unsigned errors = 0;
	int unsigned cycles = 0;

	// idling: sender 30 / receiver 80, then swapped, then none
	function automatic int unsigned idle_pct(input bit sender, input int unsigned taken);
		if (taken < 65)
			return sender ? 30 : 80;
		else if (taken < 130)
			return sender ? 80 : 30;
		return 0;
	endfunction

	function automatic lcd_write_t lcd_write(input logic rs, input logic [7:0] b,
		input logic [4:0] wb, input logic [4:0] wa);
		lcd_write_t w;
		w.reg_select     = rs;
		w.bus_byte       = b;
		w.wait_before_ms = wb;
		w.wait_after_ms  = wa;
		w.last_write     = 1'b0;
		return w;
	endfunction

	// queue up the bus writes that one accepted request should produce
	function void predict_lcd_writes(input req_t kind, input logic [7:0] ch,
		input logic line_sel, input logic pad_rest);
		logic [7:0] init_bytes[6];
		lcd_write_t w;
		int n_spaces;
		int n_new;
		n_new = 0;
		init_bytes = '{CMD_WAKE, CMD_WAKE, CMD_WAKE, CMD_FUNC_SET, CMD_DISP_ON, CMD_CLEAR};
		case (kind)
			REQ_INIT: begin
				for (int i = 0; i < 6; i++) begin
					w = lcd_write(RS_CMD, init_bytes[i], (i == 0) ? WAIT_POWER_UP : WAIT_NONE,
						(i == 5) ? WAIT_CLEAR : WAIT_CMD);
					lcd_writes_due.push_back(w);
				end
				n_new = 6;
			end
			REQ_LINE: begin
				lcd_writes_due.push_back(lcd_write(RS_CMD, line_sel ? ADDR_LINE2 : ADDR_LINE1,
					WAIT_NONE, WAIT_ADDR));
				n_new = 1;
				col_written = '0;
			end
			REQ_CHAR: begin
				lcd_writes_due.push_back(lcd_write(RS_DATA, ch, WAIT_NONE, WAIT_DATA));
				n_new = 1;
				if (col_written != COL_MAX)
					col_written = col_written + 1'b1;
			end
			default: begin
				if (pad_rest) begin
					n_spaces = (col_written < LINE_CHARS) ? LINE_CHARS - col_written : 0;
					if (n_spaces > MAX_SPACES)
						n_spaces = MAX_SPACES;
					for (int i = 0; i < n_spaces; i++)
						lcd_writes_due.push_back(lcd_write(RS_DATA, CHAR_SPACE, WAIT_NONE,
							WAIT_DATA));
					n_new = n_spaces;
					if (col_written + n_spaces > COL_MAX)
						col_written = COL_MAX;
					else
						col_written = col_written + n_spaces[5:0];
				end
			end
		endcase
		if (n_new > 0)
			lcd_writes_due[$].last_write = 1'b1;
	endfunction

	function void check_field(input string name, input int unsigned exp_v,
		input int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
			errors++;
		end
	endfunction

	task automatic add_req(input req_t kind, input logic [7:0] ch, input logic line_sel,
		input logic pad_rest, input bit drain = 0);
		lcd_req_t r;
		r.kind      = kind;
		r.char_code = ch;
		r.line_sel  = line_sel;
		r.pad_rest  = pad_rest;
		r.drain     = drain;
		req_queue.push_back(r);
	endtask

	task automatic add_rand_req(input req_t kind, input bit drain = 0);
		add_req(kind, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)),
			drain);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		lcd_req_t nxt;
		logic load;
		if (!arst_n) begin
			req_ch.valid     <= 1'b0;
			req_ch.req_type  <= REQ_INIT;
			req_ch.char_code <= '0;
			req_ch.line_sel  <= 1'b0;
			req_ch.pad_rest  <= 1'b0;
			reqs_taken       <= 0;
		end else begin
			load = 1'b0;
			if (req_ch.valid && req_ch.ready)
				reqs_taken <= reqs_taken + 1;
			if (!req_ch.valid || req_ch.ready) begin
				if (req_queue.size() != 0 && $urandom_range(99) >= idle_pct(1, reqs_taken) &&
					!(req_queue[0].drain && (req_ch.valid || writes_outstanding != 0))) begin
					nxt  = req_queue.pop_front();
					load = 1'b1;
				end
				req_ch.valid <= load;
				if (load) begin
					req_ch.req_type  <= nxt.kind;
					req_ch.char_code <= nxt.char_code;
					req_ch.line_sel  <= nxt.line_sel;
					req_ch.pad_rest  <= nxt.pad_rest;
				end
			end
		end
	end

	// monitor: predicts on request accept, checks each write, drives wr.ready
	always @(posedge clk or negedge arst_n) begin
		lcd_write_t due;
		if (!arst_n) begin
			wr_ch.ready        <= 1'b0;
			writes_outstanding <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				predict_lcd_writes(req_t'(req_ch.req_type), req_ch.char_code, req_ch.line_sel,
					req_ch.pad_rest);
			if (wr_ch.valid && wr_ch.ready) begin
				if (lcd_writes_due.size() == 0) begin
					$display("%0t: unexpected write, expected none, got rs=%0b byte=%02h",
						$time, wr_ch.reg_select, wr_ch.bus_byte);
					errors++;
				end else begin
					due = lcd_writes_due.pop_front();
					check_field("reg_select", due.reg_select, wr_ch.reg_select);
					check_field("bus_byte", due.bus_byte, wr_ch.bus_byte);
					check_field("wait_before_ms", due.wait_before_ms, wr_ch.wait_before_ms);
					check_field("wait_after_ms", due.wait_after_ms, wr_ch.wait_after_ms);
					check_field("last_write", due.last_write, wr_ch.last_write);
				end
			end
			writes_outstanding <= lcd_writes_due.size();
			wr_ch.ready <= ($urandom_range(99) >= idle_pct(0, reqs_taken));
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[char_lcd_write_sequencer] ERROR");
			$finish;
		end
	end

	initial begin
		int n_directed;
		int n_chars;
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.req_type  = REQ_INIT;
		req_ch.char_code = '0;
		req_ch.line_sel  = 1'b0;
		req_ch.pad_rest  = 1'b0;
		wr_ch.ready      = 1'b0;

		// directed: init, both lines, byte extremes, padding from several columns
		add_req(REQ_INIT, 8'hFF, 1'b1, 1'b1);
		add_req(REQ_LINE, 8'h00, 1'b0, 1'b0);
		add_req(REQ_CHAR, 8'h00, 1'b1, 1'b1);
		add_req(REQ_CHAR, 8'hFF, 1'b0, 1'b0);
		add_req(REQ_CHAR, 8'h55, 1'b0, 1'b1);
		add_req(REQ_CHAR, 8'hAA, 1'b1, 1'b0);
		add_req(REQ_END, 8'h00, 1'b0, 1'b1);   // pads the remaining 12
		add_req(REQ_END, 8'hFF, 1'b1, 1'b1);   // line already full: no writes
		add_req(REQ_LINE, 8'hFF, 1'b1, 1'b1);
		add_req(REQ_END, 8'h00, 1'b0, 1'b0);   // no padding: no writes
		add_req(REQ_END, 8'h00, 1'b0, 1'b1);   // full line of 16 spaces
		add_req(REQ_CHAR, CHAR_SPACE, 1'b0, 1'b0);
		add_req(REQ_END, 8'hFF, 1'b1, 1'b0);
		add_req(REQ_LINE, 8'hFF, 1'b0, 1'b1);
		add_req(REQ_CHAR, 8'h7F, 1'b0, 1'b0);
		add_req(REQ_CHAR, 8'h80, 1'b1, 1'b1);
		add_req(REQ_END, 8'h00, 1'b1, 1'b1);
		add_req(REQ_INIT, 8'h00, 1'b0, 1'b0);
		add_req(REQ_END, 8'h00, 1'b0, 1'b1);
		n_directed = req_queue.size();

		// long line after a begin: column counter saturates, padding then does nothing
		add_rand_req(REQ_LINE, 1);
		for (int i = 0; i < 66; i++)
			add_rand_req(REQ_CHAR);
		add_req(REQ_END, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);

		// mostly well-formed lines with random content, some init and noise
		while (req_queue.size() < n_directed + RANDOM_REQS) begin
			case ($urandom_range(9))
				0: add_rand_req(REQ_INIT);
				1: add_rand_req(req_t'($urandom_range(3)));
				default: begin
					add_rand_req(REQ_LINE);
					n_chars = ($urandom_range(7) == 0) ? $urandom_range(17, 24)
						: $urandom_range(0, 16);
					for (int i = 0; i < n_chars; i++)
						add_rand_req(REQ_CHAR);
					add_req(REQ_END, 8'($urandom_range(255)), 1'($urandom_range(1)),
						1'($urandom_range(3) != 0));
				end
			endcase
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (req_queue.size() != 0 || req_ch.valid)
			@(negedge clk);
		while (lcd_writes_due.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (lcd_writes_due.size() != 0) begin
			$display("%0t: %0d writes expected, got none", $time, lcd_writes_due.size());
			errors++;
		end
		if (errors == 0)
			$display("[char_lcd_write_sequencer] OK");
		else
			$display("[char_lcd_write_sequencer] ERROR");
		$finish;
	end

endmodule

// ----- char_lcd_write_sequencer.f -----
+incdir+sv
sv/clws_pkg.sv
sv/clws_req_if.sv
sv/clws_wr_if.sv
sv/clws_ctrl.sv
sv/clws_dp.sv
sv/char_lcd_write_sequencer.sv
verif/tb_char_lcd_write_sequencer.sv
